/* rtl/cio_pkg.sv */
// ----------------------------------------------------------------------------
// cio_pkg
// Types, address map and wait-state tables for the console I/O register block.
// ----------------------------------------------------------------------------
package cio_pkg;

	localparam logic [31:0] MAP_BASE = 32'h0400_0000;
	localparam int          OFF_W    = 10;

	typedef logic [OFF_W-1:0] off_t;

	localparam off_t MAP_LAST    = 10'h301;
	localparam off_t OFF_DISPSTAT = 10'h004;
	localparam off_t OFF_VCOUNT_HI = 10'h007;
	localparam off_t OFF_DMA_LO  = 10'h0b0;
	localparam off_t OFF_DMA_HI  = 10'h0df;
	localparam off_t OFF_TMR_LO  = 10'h100;
	localparam off_t OFF_TMR_HI  = 10'h10f;
	localparam off_t OFF_KEY_LO  = 10'h130;
	localparam off_t OFF_KEY_HI  = 10'h131;
	localparam off_t OFF_IE_LO   = 10'h200;
	localparam off_t OFF_IE_HI   = 10'h201;
	localparam off_t OFF_IF_LO   = 10'h202;
	localparam off_t OFF_IF_HI   = 10'h203;
	localparam off_t OFF_WC_LO   = 10'h204;
	localparam off_t OFF_WC_HI   = 10'h207;
	localparam off_t OFF_IME_LO  = 10'h208;
	localparam off_t OFF_IME_HI  = 10'h20b;
	localparam off_t OFF_HALT    = 10'h301;

	localparam int   DMA_STRIDE  = 12;
	localparam int   DMA_CTRL_HI = 11;
	localparam logic [7:0] STAT_KEEP = 8'h47;
	localparam int   ENABLE_POS  = 7;
	localparam int   WORD_POS    = 2;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_IRQ   = 2'd2,
		REQ_HW    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		RSEL_ZERO = 2'd0,
		RSEL_MEM  = 2'd1,
		RSEL_BYTE = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] address;
		logic [7:0]  write_data;
		logic [15:0] irq_flags;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        irq_recheck;
		logic        dma_start;
		logic [1:0]  dma_channel;
		logic [31:0] dma_src;
		logic [31:0] dma_dst;
		logic [15:0] dma_len;
		logic [3:0]  timer_enable_mask;
		logic [3:0]  timer_restart;
		logic        halted;
		logic [59:0] wait_table;
	} rsp_t;

	typedef struct packed {
		logic clear_en;
		logic accept;
		logic load_out;
	} cio_cmd_t;

	typedef struct packed {
		logic clear_done;
	} cio_stat_t;

	function automatic logic rd_mapped(input off_t o);
		case (o) inside
			[10'h000:10'h001], [10'h004:10'h00f], [10'h048:10'h04b], [10'h050:10'h051],
			[10'h060:10'h065], [10'h068:10'h069], [10'h06c:10'h06d], [10'h070:10'h075],
			[10'h078:10'h079], [10'h07c:10'h07d], [10'h080:10'h085], [10'h088:10'h089],
			[10'h0ba:10'h0bb], [10'h0c6:10'h0c7], [10'h0d2:10'h0d3], [10'h0de:10'h0df],
			[10'h100:10'h10f], [10'h120:10'h123], [10'h128:10'h12a], [10'h130:10'h131],
			[10'h134:10'h135], [10'h200:10'h20b], [10'h300:10'h300]: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic wr_mapped(input off_t o);
		case (o) inside
			[10'h000:10'h001], [10'h004:10'h005], [10'h008:10'h01f], [10'h028:10'h02f],
			[10'h038:10'h03f], [10'h048:10'h04b], [10'h050:10'h051], [10'h060:10'h065],
			[10'h068:10'h069], [10'h06c:10'h06d], [10'h070:10'h075], [10'h078:10'h079],
			[10'h07c:10'h07d], [10'h080:10'h085], [10'h088:10'h089], [10'h0b0:10'h0df],
			[10'h100:10'h10f], [10'h120:10'h123], [10'h128:10'h12a], [10'h134:10'h135],
			[10'h200:10'h20b], [10'h300:10'h301]: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [4:0] nseq_cycles(input logic [1:0] code);
		case (code)
			2'd0:    return 5'd4;
			2'd1:    return 5'd3;
			2'd2:    return 5'd2;
			default: return 5'd8;
		endcase
	endfunction

	function automatic logic [4:0] seq_cycles(input logic [1:0] region, input logic code);
		if (code) begin
			return 5'd1;
		end
		case (region)
			2'd0:    return 5'd2;
			2'd1:    return 5'd4;
			default: return 5'd8;
		endcase
	endfunction

	function automatic logic [59:0] wait_decode(input logic [31:0] wc);
		logic [59:0] t;
		logic [4:0]  n16, s16, n32, s32;
		t = '0;
		for (int r = 0; r < 3; r++) begin
			n16 = nseq_cycles(wc[2+3*r +: 2]) + 5'd1;
			s16 = seq_cycles(2'(r), wc[4+3*r]) + 5'd1;
			n32 = n16 + s16;
			s32 = {s16[3:0], 1'b0};
			t[20*r +: 20] = {s32, n32, s16, n16};
		end
		return t;
	endfunction

endpackage

/* rtl/cio_if.sv */
// ----------------------------------------------------------------------------
// cio_req_if / cio_rsp_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
interface cio_req_if;
	import cio_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cio_rsp_if;
	import cio_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/cio_ctrl.sv */
// ----------------------------------------------------------------------------
// cio_ctrl
// Sequencer: clearing pass after reset, request intake, result hand-off.
// ----------------------------------------------------------------------------
module cio_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output cio_pkg::cio_cmd_t  cmd,
	input  cio_pkg::cio_stat_t stat
);
	import cio_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_RESP  = 3'b100
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free     = !rsp_valid_q || rsp_ready;
	assign req_ready    = (state_q == ST_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign cmd.clear_en = (state_q == ST_CLEAR);
	assign cmd.accept   = req_valid && req_ready;
	assign cmd.load_out = (state_q == ST_RESP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: if (stat.clear_done) begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: if (cmd.accept) begin
					state_q <= ST_RESP;
				end
				ST_RESP: if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end
endmodule

/* rtl/cio_dpath.sv */
// ----------------------------------------------------------------------------
// cio_dpath
// Register byte store, side-effect registers, address decode, result register.
// ----------------------------------------------------------------------------
module cio_dpath #(
	parameter int IO_SPAN = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cio_pkg::cio_cmd_t  cmd,
	output cio_pkg::cio_stat_t stat,
	input  cio_pkg::req_t      req,
	output cio_pkg::rsp_t      rsp
);
	import cio_pkg::*;

	localparam int AW = $clog2(IO_SPAN);

	logic [7:0]    mem [IO_SPAN];
	logic [7:0]    mem_rd_q;
	logic [AW-1:0] clr_addr_q;

	// side-effect registers, some of them shadows of bytes also held in the store
	logic [7:0]    dma_q [4][DMA_STRIDE];
	logic [15:0]   reload_q [4];
	logic [15:0]   count_q [4];
	logic [3:0]    tmr_en_q;
	logic          halt_q;
	logic [15:0]   if_q;
	logic [7:0]    stat_q;
	logic [31:0]   wc_q;

	rsp_t          pend_q;
	rd_sel_t       rsel_q;
	logic [7:0]    rbyte_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;

	logic [31:0]   off_full;
	logic          mapped;
	off_t          off;
	logic [AW-1:0] maddr;
	req_kind_t     kind;
	logic [7:0]    v;
	off_t          dma_rel;
	logic [1:0]    dma_ch;
	logic [3:0]    dma_idx;
	logic          in_dma, in_tmr;
	logic [1:0]    tn;
	logic          wr_ok;

	logic          mem_we;
	logic [7:0]    mem_wd;
	logic          stat_we, dma_we, rl_we, en_we, cnt_ld, wc_we, if_clr, irq;
	logic          halt_set;
	rsp_t          pend_d;
	rd_sel_t       rsel_d;
	logic [7:0]    rbyte_d;
	logic [31:0]   mask;

	assign off_full = req.address - MAP_BASE;
	assign mapped   = off_full <= 32'(MAP_LAST);
	assign off      = off_full[OFF_W-1:0];
	assign maddr    = off_full[AW-1:0];
	assign kind     = req_kind_t'(req.req_type);
	assign v        = req.write_data;
	assign in_dma   = off >= OFF_DMA_LO && off <= OFF_DMA_HI;
	assign in_tmr   = off >= OFF_TMR_LO && off <= OFF_TMR_HI;
	assign tn       = off[3:2];
	assign dma_rel  = off - OFF_DMA_LO;
	assign wr_ok    = mapped && wr_mapped(off);

	always_comb begin
		dma_ch  = '0;
		dma_idx = '0;
		for (int c = 0; c < 4; c++) begin
			if (dma_rel >= off_t'(DMA_STRIDE*c) && dma_rel < off_t'(DMA_STRIDE*c + DMA_STRIDE)) begin
				dma_ch  = 2'(c);
				dma_idx = 4'(dma_rel - off_t'(DMA_STRIDE*c));
			end
		end
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_wd   = v;
		stat_we  = 1'b0;
		dma_we   = 1'b0;
		rl_we    = 1'b0;
		en_we    = 1'b0;
		cnt_ld   = 1'b0;
		wc_we    = 1'b0;
		if_clr   = 1'b0;
		irq      = 1'b0;
		halt_set = 1'b0;
		rsel_d   = RSEL_ZERO;
		rbyte_d  = '0;
		pend_d   = '0;
		mask     = v[WORD_POS] ? ~32'd3 : ~32'd1;
		case (kind)
			REQ_READ: if (mapped && rd_mapped(off)) begin
				if (in_tmr && !off[1]) begin
					rsel_d  = RSEL_BYTE;
					rbyte_d = off[0] ? count_q[tn][15:8] : count_q[tn][7:0];
				end else if (off == OFF_IF_LO) begin
					rsel_d  = RSEL_BYTE;
					rbyte_d = if_q[7:0];
				end else if (off == OFF_IF_HI) begin
					rsel_d  = RSEL_BYTE;
					rbyte_d = if_q[15:8];
				end else begin
					rsel_d = RSEL_MEM;
				end
			end
			REQ_WRITE: if (wr_ok) begin
				if (off == OFF_DISPSTAT) begin
					mem_we  = 1'b1;
					mem_wd  = (stat_q & STAT_KEEP) | (v & ~STAT_KEEP);
					stat_we = 1'b1;
				end else if (off == OFF_IF_LO || off == OFF_IF_HI) begin
					if_clr = 1'b1;
				end else if (off == OFF_HALT) begin
					halt_set = 1'b1;
				end else if (in_dma && dma_idx == 4'(DMA_CTRL_HI)) begin
					mem_we = 1'b1;
					dma_we = 1'b1;
					if (v[ENABLE_POS] && !dma_q[dma_ch][DMA_CTRL_HI][ENABLE_POS]) begin
						pend_d.dma_start   = 1'b1;
						pend_d.dma_channel = dma_ch;
						pend_d.dma_src     = {dma_q[dma_ch][3], dma_q[dma_ch][2],
							dma_q[dma_ch][1], dma_q[dma_ch][0]} & mask;
						pend_d.dma_dst     = {dma_q[dma_ch][7], dma_q[dma_ch][6],
							dma_q[dma_ch][5], dma_q[dma_ch][4]} & mask;
						pend_d.dma_len     = {dma_q[dma_ch][9], dma_q[dma_ch][8]};
					end
				end else if (in_tmr && off[1:0] == 2'd2) begin
					mem_we = 1'b1;
					en_we  = 1'b1;
					if (v[ENABLE_POS] && !tmr_en_q[tn]) begin
						cnt_ld = 1'b1;
						pend_d.timer_restart[tn] = 1'b1;
					end
				end else begin
					mem_we = 1'b1;
					dma_we = in_dma;
					rl_we  = in_tmr && !off[1];
					wc_we  = off >= OFF_WC_LO && off <= OFF_WC_HI;
					pend_d.irq_recheck = off == OFF_IE_LO || off == OFF_IE_HI ||
						(off >= OFF_IME_LO && off <= OFF_IME_HI);
				end
			end
			REQ_IRQ: begin
				irq = 1'b1;
				pend_d.irq_recheck = 1'b1;
			end
			REQ_HW: if (mapped && ((off >= OFF_DISPSTAT && off <= OFF_VCOUNT_HI) ||
					off == OFF_KEY_LO || off == OFF_KEY_HI)) begin
				mem_we  = 1'b1;
				stat_we = off == OFF_DISPSTAT;
			end
			default: ;
		endcase
	end

	// byte store: one write and one registered read per cycle; read data is
	// held until the result is loaded
	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.accept && mem_we) begin
			mem[maddr] <= mem_wd;
		end
		if (cmd.accept) begin
			mem_rd_q <= mem[maddr];
		end
	end

	assign stat.clear_done = clr_addr_q == AW'(IO_SPAN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_en && !stat.clear_done) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_q    <= '{default: '{default: '0}};
			reload_q <= '{default: '0};
			count_q  <= '{default: '0};
			tmr_en_q <= '0;
			halt_q   <= 1'b0;
			if_q     <= '0;
			stat_q   <= '0;
			wc_q     <= '0;
		end else if (cmd.accept) begin
			if (dma_we) begin
				dma_q[dma_ch][dma_idx] <= v;
			end
			if (rl_we) begin
				if (off[0]) begin
					reload_q[tn][15:8] <= v;
				end else begin
					reload_q[tn][7:0] <= v;
				end
			end
			if (en_we) begin
				tmr_en_q[tn] <= v[ENABLE_POS];
			end
			if (cnt_ld) begin
				count_q[tn] <= reload_q[tn];
			end
			if (wc_we) begin
				wc_q[8*off[1:0] +: 8] <= v;
			end
			if (stat_we) begin
				stat_q <= mem_wd;
			end
			if (if_clr) begin
				if (off[0]) begin
					if_q[15:8] <= if_q[15:8] & ~v;
				end else begin
					if_q[7:0] <= if_q[7:0] & ~v;
				end
			end
			if (irq) begin
				if_q   <= if_q | req.irq_flags;
				halt_q <= 1'b0;
			end else if (halt_set) begin
				halt_q <= 1'b1;
			end
		end
	end

	always_comb begin
		rsp_d = pend_q;
		case (rsel_q)
			RSEL_MEM:  rsp_d.read_data = mem_rd_q;
			RSEL_BYTE: rsp_d.read_data = rbyte_q;
			default:   rsp_d.read_data = '0;
		endcase
		rsp_d.timer_enable_mask = tmr_en_q;
		rsp_d.halted            = halt_q;
		rsp_d.wait_table        = wait_decode(wc_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_q  <= pend_d;
			rsel_q  <= rsel_d;
			rbyte_q <= rbyte_d;
		end
		if (cmd.load_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;
endmodule

/* rtl/console_io_register_block_top.sv */
// ----------------------------------------------------------------------------
// console_io_register_block_top
// Byte-wide memory-mapped I/O register block with DMA, timer and IRQ strobes.
// ----------------------------------------------------------------------------
// A request is accepted, then its result is loaded into the output register
// once that register is free (a stall can come between), since the byte store
// is a single-port memory with registered read data. A new request is taken
// once the previous result has gone into the output register. After reset the
// store is swept to zero, one byte a cycle; no request is accepted before it ends.
module console_io_register_block_top #(
	parameter int IO_SPAN = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	cio_req_if.sink          req,
	cio_rsp_if.source        rsp
);
	import cio_pkg::*;

	cio_cmd_t  cmd;
	cio_stat_t stat;

	cio_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	cio_dpath #(
		.IO_SPAN (IO_SPAN)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req.data),
		.rsp    (rsp.data)
	);
endmodule

/* verif/console_io_register_block_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_io_register_block_top_tb
// Self-checking bench for the console I/O register block. A directed table
// covers reset values, the address map edges and side-effect addresses.
// A random bus traffic phase follows. Every result is compared field by field
// with a register-file shadow that is updated on each accepted request.
// ----------------------------------------------------------------------------
module console_io_register_block_top_tb;
	import cio_pkg::*;

	localparam int SPAN = 1024;

	typedef struct {
		req_t       r;
		bit         chk;
		logic [7:0] rd;
	} row_t;

	logic clk;
	logic arst_n;

	cio_req_if req ();
	cio_rsp_if rsp ();

	console_io_register_block_top #(.IO_SPAN(SPAN)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow register file
	logic [7:0]  shadow_bytes [SPAN];
	logic [15:0] shadow_counts [4];
	logic [3:0]  shadow_tmr_en;
	logic        shadow_halt;
	logic [59:0] shadow_wait;

	rsp_t       pending_rsp [$];
	bit         pending_chk [$];
	logic [7:0] pending_rd [$];
	int         n_errors;
	row_t       dir_rows [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [19:0] region_waits(input int r, input logic [1:0] n,
	                                             input logic s);
		logic [4:0] n16, s16, n32, s32;
		case (n)
			2'd0:    n16 = 5'd5;
			2'd1:    n16 = 5'd4;
			2'd2:    n16 = 5'd3;
			default: n16 = 5'd9;
		endcase
		if (s)
			s16 = 5'd2;
		else
			s16 = (r == 0) ? 5'd3 : (r == 1) ? 5'd5 : 5'd9;
		n32 = n16 + s16;
		s32 = s16 << 1;
		return {s32, n32, s16, n16};
	endfunction

	function automatic void refresh_waits();
		logic [31:0] wc;
		wc = {shadow_bytes[10'h207], shadow_bytes[10'h206], shadow_bytes[10'h205],
		      shadow_bytes[10'h204]};
		for (int r = 0; r < 3; r++)
			shadow_wait[20*r +: 20] = region_waits(r, wc[2+3*r +: 2], wc[4+3*r]);
	endfunction

	function automatic void shadow_reset();
		for (int i = 0; i < SPAN; i++)
			shadow_bytes[i] = 8'h00;
		for (int i = 0; i < 4; i++)
			shadow_counts[i] = 16'h0;
		shadow_tmr_en = 4'h0;
		shadow_halt   = 1'b0;
		refresh_waits();
	endfunction

	function automatic logic [15:0] half_at(input int o);
		return {shadow_bytes[o+1], shadow_bytes[o]};
	endfunction

	function automatic logic [31:0] word_at(input int o);
		return {shadow_bytes[o+3], shadow_bytes[o+2], shadow_bytes[o+1], shadow_bytes[o]};
	endfunction

	function automatic rsp_t bus_access(input req_t r);
		rsp_t        o;
		logic [31:0] off32;
		int          off, ch, base, t;
		logic [7:0]  v, prev;
		logic [31:0] amask;
		logic [15:0] ctl;
		bit          mapped;
		o      = '0;
		off32  = r.address - MAP_BASE;
		mapped = off32 <= 32'h301;
		off    = int'(off32[9:0]);
		v      = r.write_data;
		case (req_kind_t'(r.req_type))
			REQ_READ: begin
				if (mapped && rd_mapped(off_t'(off))) begin
					if (off >= 'h100 && off <= 'h10f && (off & 3) < 2) begin
						t = (off - 'h100) >> 2;
						o.read_data = (off & 1) ? shadow_counts[t][15:8] : shadow_counts[t][7:0];
					end else begin
						o.read_data = shadow_bytes[off];
					end
				end
			end
			REQ_WRITE: begin
				if (mapped && wr_mapped(off_t'(off))) begin
					if (off == 'h004) begin
						shadow_bytes[off] = (shadow_bytes[off] & STAT_KEEP) | (v & ~STAT_KEEP);
					end else if (off == 'h202 || off == 'h203) begin
						shadow_bytes[off] = shadow_bytes[off] & ~v;
					end else if (off == 'h301) begin
						shadow_halt = 1'b1;
					end else if (off >= 'h0b0 && off <= 'h0df && (off - 'h0b0) % 12 == 11) begin
						ch   = (off - 'h0b0) / 12;
						base = 'h0b0 + 12 * ch;
						prev = shadow_bytes[off];
						shadow_bytes[off] = v;
						if (!prev[7] && v[7]) begin
							ctl           = half_at(base + 10);
							amask         = ctl[10] ? ~32'd3 : ~32'd1;
							o.dma_start   = 1'b1;
							o.dma_channel = 2'(ch);
							o.dma_src     = word_at(base) & amask;
							o.dma_dst     = word_at(base + 4) & amask;
							o.dma_len     = half_at(base + 8);
						end
					end else if (off >= 'h100 && off <= 'h10f && (off & 3) == 2) begin
						t    = (off - 'h100) >> 2;
						prev = shadow_bytes[off];
						shadow_bytes[off] = v;
						shadow_tmr_en[t]  = v[7];
						if (!prev[7] && v[7]) begin
							shadow_counts[t]   = half_at('h100 + 4 * t);
							o.timer_restart[t] = 1'b1;
						end
					end else begin
						shadow_bytes[off] = v;
						if (off == 'h200 || off == 'h201 || (off >= 'h208 && off <= 'h20b))
							o.irq_recheck = 1'b1;
						if (off >= 'h204 && off <= 'h207)
							refresh_waits();
					end
				end
			end
			REQ_IRQ: begin
				shadow_bytes['h202] = shadow_bytes['h202] | r.irq_flags[7:0];
				shadow_bytes['h203] = shadow_bytes['h203] | r.irq_flags[15:8];
				shadow_halt   = 1'b0;
				o.irq_recheck = 1'b1;
			end
			default: begin
				// status bytes owned by hardware: stored whole, no side effects
				if (mapped && ((off >= 'h004 && off <= 'h007) || off == 'h130 || off == 'h131))
					shadow_bytes[off] = v;
			end
		endcase
		o.timer_enable_mask = shadow_tmr_en;
		o.halted            = shadow_halt;
		o.wait_table        = shadow_wait;
		return o;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// acceptance of a request updates the shadow
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			pending_rsp.push_back(bus_access(req.data));
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		bit   c;
		logic [7:0] d;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0 || pending_chk.size() == 0) begin
				report("unexpected result", rsp.data.read_data, 0);
			end else begin
				e = pending_rsp.pop_front();
				c = pending_chk.pop_front();
				d = pending_rd.pop_front();
				if (c && rsp.data.read_data !== d)
					report("read_data (table)", rsp.data.read_data, d);
				if (rsp.data.read_data !== e.read_data)
					report("read_data", rsp.data.read_data, e.read_data);
				if (rsp.data.irq_recheck !== e.irq_recheck)
					report("irq_recheck", rsp.data.irq_recheck, e.irq_recheck);
				if (rsp.data.dma_start !== e.dma_start)
					report("dma_start", rsp.data.dma_start, e.dma_start);
				if (rsp.data.dma_channel !== e.dma_channel)
					report("dma_channel", rsp.data.dma_channel, e.dma_channel);
				if (rsp.data.dma_src !== e.dma_src)
					report("dma_src", rsp.data.dma_src, e.dma_src);
				if (rsp.data.dma_dst !== e.dma_dst)
					report("dma_dst", rsp.data.dma_dst, e.dma_dst);
				if (rsp.data.dma_len !== e.dma_len)
					report("dma_len", rsp.data.dma_len, e.dma_len);
				if (rsp.data.timer_enable_mask !== e.timer_enable_mask)
					report("timer_enable_mask", rsp.data.timer_enable_mask, e.timer_enable_mask);
				if (rsp.data.timer_restart !== e.timer_restart)
					report("timer_restart", rsp.data.timer_restart, e.timer_restart);
				if (rsp.data.halted !== e.halted)
					report("halted", rsp.data.halted, e.halted);
				if (rsp.data.wait_table !== e.wait_table)
					report("wait_table", rsp.data.wait_table, e.wait_table);
			end
		end
	end

	function automatic req_t mk(input req_kind_t k, input logic [31:0] a,
	                            input logic [7:0] d, input logic [15:0] f);
		req_t r;
		r.req_type   = k;
		r.address    = a;
		r.write_data = d;
		r.irq_flags  = f;
		return r;
	endfunction

	function automatic void add_row(input req_t r, input bit c, input logic [7:0] d);
		row_t w;
		w.r   = r;
		w.chk = c;
		w.rd  = d;
		dir_rows.push_back(w);
	endfunction

	function automatic logic [31:0] pick_address();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return $urandom();
		if (sel < 25)
			return MAP_BASE + 32'h0b0 + $urandom_range(0, 'h2f);
		if (sel < 40)
			return MAP_BASE + 32'h100 + $urandom_range(0, 'h0f);
		if (sel < 55)
			return MAP_BASE + 32'h200 + $urandom_range(0, 'h0b);
		if (sel < 60)
			return MAP_BASE + 32'h300 + $urandom_range(0, 3);
		return MAP_BASE + $urandom_range(0, 'h303);
	endfunction

	// one request; valid stays high across back-to-back transfers
	task automatic offer(input req_t r, input bit c, input logic [7:0] d);
		req.valid <= 1'b1;
		req.data  <= r;
		pending_chk.push_back(c);
		pending_rd.push_back(d);
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic pace(inout int burst_left);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// receiver: its own stall pattern plus one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 200 == 0)
				mode = $urandom_range(0, 2);
			if (cyc >= 3000 && cyc < 3400)
				rsp.ready <= 1'b0;
			else if (mode == 0)
				rsp.ready <= 1'b1;
			else if (mode == 1)
				rsp.ready <= ($urandom_range(0, 3) != 0);
			else
				rsp.ready <= ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int burst;
		n_errors  = 0;
		burst     = 0;
		req.valid = 1'b0;
		req.data  = '0;
		arst_n    = 1'b0;
		shadow_reset();

		add_row(mk(REQ_READ, MAP_BASE, 8'h00, 16'h0), 1, 8'h00);
		add_row(mk(REQ_READ, 32'hffff_ffff, 8'h00, 16'hffff), 1, 8'h00);
		add_row(mk(REQ_WRITE, 32'h0000_0000, 8'hff, 16'h0), 0, 8'h00);
		add_row(mk(REQ_READ, MAP_BASE + 32'h302, 8'h00, 16'h0), 1, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h301, 8'h00, 16'h0), 0, 8'h00);
		add_row(mk(REQ_READ, MAP_BASE + 32'h301, 8'h00, 16'h0), 1, 8'h00);
		add_row(mk(REQ_IRQ, 32'h0, 8'h00, 16'hffff), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h202, 8'h0f, 16'h0), 0, 8'h00);
		add_row(mk(REQ_READ, MAP_BASE + 32'h202, 8'h00, 16'h0), 1, 8'hf0);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h200, 8'hff, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h20b, 8'h01, 16'h0), 0, 8'h00);
		add_row(mk(REQ_HW, MAP_BASE + 32'h004, 8'hff, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h004, 8'h00, 16'h0), 0, 8'h00);
		add_row(mk(REQ_READ, MAP_BASE + 32'h004, 8'h00, 16'h0), 1, 8'h47);
		add_row(mk(REQ_HW, MAP_BASE + 32'h131, 8'ha5, 16'h0), 0, 8'h00);
		add_row(mk(REQ_HW, MAP_BASE + 32'h000, 8'ha5, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h0b3, 8'h81, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h0b0, 8'hff, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h0b8, 8'h34, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h0bb, 8'h84, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h100, 8'hcd, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h102, 8'h80, 16'h0), 0, 8'h00);
		add_row(mk(REQ_READ, MAP_BASE + 32'h100, 8'h00, 16'h0), 1, 8'hcd);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h204, 8'hff, 16'h0), 0, 8'h00);
		add_row(mk(REQ_WRITE, MAP_BASE + 32'h205, 8'hff, 16'h0), 0, 8'h00);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			offer(dir_rows[i].r, dir_rows[i].chk, dir_rows[i].rd);
			pace(burst);
		end
		for (int i = 0; i < 2000; i++) begin
			req_t r;
			r.req_type   = 2'($urandom_range(0, 3));
			r.address    = pick_address();
			r.write_data = 8'($urandom());
			r.irq_flags  = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom());
			offer(r, 0, 8'h00);
			pace(burst);
		end
		req.valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("console_io_register_block_top_tb: clean");
		else
			$display("console_io_register_block_top_tb: errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("console_io_register_block_top_tb: errors");
		$finish;
	end

endmodule
